[hdl/vuc_pkg.sv]
// Shared types and constants for the unsigned 64-bit varint codec.
// No dependencies; used by varint_u64_codec.
package vuc_pkg;

   // Field widths
   localparam int ValueWidth  = 64;
   localparam int ByteWidth   = 8;
   localparam int LengthWidth = 4;
   localparam int KindWidth   = 2;
   localparam int StatusWidth = 2;

   // Format constants
   localparam int MaxBytes   = 10;   // decode byte limit, 2 to 10
   localparam int ValueBits  = 64;   // significant value bits, 8 to 64
   localparam int HardBytes  = 10;   // longest encoding of a 64-bit value
   localparam int GroupBits  = 7;
   localparam int SeenBits   = 4;
   localparam int AccBits    = (MaxBytes * GroupBits > ValueWidth) ?
                               MaxBytes * GroupBits : ValueWidth;

   localparam logic [ValueWidth-1:0] ValueMask = {ValueWidth{1'b1}} >> (ValueWidth - ValueBits);

   // Action codes
   localparam logic ActEncode = 1'b0;
   localparam logic ActDecode = 1'b1;

   // Result kinds
   localparam logic [KindWidth-1:0] KindByte  = 2'd0;
   localparam logic [KindWidth-1:0] KindValue = 2'd1;
   localparam logic [KindWidth-1:0] KindError = 2'd2;

   // Status codes
   localparam logic [StatusWidth-1:0] StOk       = 2'd0;
   localparam logic [StatusWidth-1:0] StTooShort = 2'd1;
   localparam logic [StatusWidth-1:0] StBadData  = 2'd2;

   typedef struct packed {
      logic                  action;
      logic [ValueWidth-1:0] value_in;
      logic [ByteWidth-1:0]  byte_in;
      logic                  end_of_buffer;
   } req_type;

   typedef struct packed {
      logic [KindWidth-1:0]   kind;
      logic [ByteWidth-1:0]   byte_out;
      logic [ValueWidth-1:0]  value_out;
      logic [LengthWidth-1:0] length;
      logic [StatusWidth-1:0] status;
      logic                   last;
   } rsp_type;

endpackage

[hdl/varint_u64_codec.sv]
// Unsigned LEB128 varint codec, 64-bit values: encoder and decoder in one module.
// Depends on vuc_pkg for the request and response types and format constants.
//
// Usage:
//   The request channel (req_valid / req_ready / req_payload) carries one request
//   per handshake. An encode request (action 0) carries value_in; a decode
//   request (action 1) carries one stream byte in byte_in plus end_of_buffer.
//   The response channel (rsp_valid / rsp_ready / rsp_payload) is driven from
//   an output register, so a response appears the cycle after the request that
//   causes it.
//   Encoding: the value goes into a 7-bit-digit shift register; one byte leaves
//   per cycle unless stalled, low group first, bit 7 set on all but the last.
//   A request yields 1 to 10 bytes, set by the number of groups in the value, and
//   req_ready stays low until the last byte has been loaded into the output
//   register. Decoding: one byte per cycle when not stalled. Each 7-bit group
//   lands in the digit slot that the byte count selects. The byte with bit 7
//   clear returns the value and its length; a continuing tenth byte returns
//   bad_data, a continuing byte marked end_of_buffer returns too_short.
//   Other bytes return nothing. Encode requests leave an open decode untouched.
//   Stall: while rsp_ready is low and a response waits, req_ready is low and
//   the encoder holds its position; nothing is dropped.
//   Reset (synchronous, active high) empties the output register, stops the
//   encoder and clears the decode accumulator and byte count.
module varint_u64_codec (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  vuc_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output vuc_pkg::rsp_type rsp_payload
);

   // Output register
   logic             rsp_valid_ff, rsp_valid_in;
   vuc_pkg::rsp_type rsp_data_ff, rsp_data_in;

   // Encoder digit shift register
   logic                                  enc_busy_ff, enc_busy_in;
   logic [vuc_pkg::ValueWidth-1:0]        enc_value_ff, enc_value_in;
   logic [vuc_pkg::SeenBits-1:0]          enc_count_ff, enc_count_in;

   // Decoder digit slots and byte count
   logic [vuc_pkg::GroupBits-1:0]         slot_ff [vuc_pkg::MaxBytes];
   logic [vuc_pkg::GroupBits-1:0]         slot_in [vuc_pkg::MaxBytes];
   logic [vuc_pkg::SeenBits-1:0]          dec_seen_ff, dec_seen_in;

   logic                                  out_free;
   logic                                  req_fire;
   logic                                  enc_more;
   logic [vuc_pkg::ValueWidth-1:0]        req_value;
   logic                                  req_more;
   logic [vuc_pkg::GroupBits-1:0]         slot_new [vuc_pkg::MaxBytes];
   logic [vuc_pkg::AccBits-1:0]           acc_wide;
   logic [vuc_pkg::SeenBits-1:0]          seen_next;

   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign req_ready   = !enc_busy_ff && out_free;
   assign req_fire    = req_valid && req_ready;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

   // More groups follow while anything is left above the low digit, capped at
   // the longest encoding.
   assign enc_more  = (enc_value_ff[vuc_pkg::ValueWidth-1:vuc_pkg::GroupBits] != '0) &&
                      (enc_count_ff < vuc_pkg::SeenBits'(vuc_pkg::HardBytes - 1));
   assign req_value = req_payload.value_in & vuc_pkg::ValueMask;
   assign req_more  = req_value[vuc_pkg::ValueWidth-1:vuc_pkg::GroupBits] != '0;
   assign seen_next = dec_seen_ff + 1'b1;

   // Drop the new group into the slot picked by the byte count
   always_comb begin
      acc_wide = '0;
      for (int i = 0; i < vuc_pkg::MaxBytes; i++) begin
         slot_new[i] = (vuc_pkg::SeenBits'(i) == dec_seen_ff) ?
                       req_payload.byte_in[vuc_pkg::GroupBits-1:0] : slot_ff[i];
         acc_wide[i*vuc_pkg::GroupBits +: vuc_pkg::GroupBits] = slot_new[i];
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      enc_busy_in  = enc_busy_ff;
      enc_value_in = enc_value_ff;
      enc_count_in = enc_count_ff;
      slot_in      = slot_ff;
      dec_seen_in  = dec_seen_ff;

      // Release the output register once the response is taken
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (enc_busy_ff && out_free) begin
         // Emit the next digit and advance the shift register
         rsp_valid_in          = 1'b1;
         rsp_data_in           = '0;
         rsp_data_in.kind      = vuc_pkg::KindByte;
         rsp_data_in.byte_out  = {enc_more, enc_value_ff[vuc_pkg::GroupBits-1:0]};
         rsp_data_in.status    = vuc_pkg::StOk;
         rsp_data_in.last      = !enc_more;
         enc_value_in          = enc_value_ff >> vuc_pkg::GroupBits;
         enc_count_in          = enc_count_ff + 1'b1;
         enc_busy_in           = enc_more;
      end else if (req_fire) begin
         rsp_data_in = '0;
         if (req_payload.action == vuc_pkg::ActEncode) begin
            // First digit straight from the request; the rest from the shifter
            rsp_valid_in         = 1'b1;
            rsp_data_in.kind     = vuc_pkg::KindByte;
            rsp_data_in.byte_out = {req_more, req_value[vuc_pkg::GroupBits-1:0]};
            rsp_data_in.status   = vuc_pkg::StOk;
            rsp_data_in.last     = !req_more;
            enc_value_in         = req_value >> vuc_pkg::GroupBits;
            enc_count_in         = vuc_pkg::SeenBits'(1);
            enc_busy_in          = req_more;
         end else begin
            slot_in     = slot_new;
            dec_seen_in = seen_next;
            if (!req_payload.byte_in[vuc_pkg::ByteWidth-1]) begin
               rsp_valid_in          = 1'b1;
               rsp_data_in.kind      = vuc_pkg::KindValue;
               rsp_data_in.value_out = acc_wide[vuc_pkg::ValueWidth-1:0] & vuc_pkg::ValueMask;
               rsp_data_in.length    = seen_next;
               rsp_data_in.status    = vuc_pkg::StOk;
               rsp_data_in.last      = 1'b1;
            end else if (seen_next >= vuc_pkg::SeenBits'(vuc_pkg::MaxBytes)) begin
               rsp_valid_in       = 1'b1;
               rsp_data_in.kind   = vuc_pkg::KindError;
               rsp_data_in.status = vuc_pkg::StBadData;
               rsp_data_in.last   = 1'b1;
            end else if (req_payload.end_of_buffer) begin
               rsp_valid_in       = 1'b1;
               rsp_data_in.kind   = vuc_pkg::KindError;
               rsp_data_in.status = vuc_pkg::StTooShort;
               rsp_data_in.last   = 1'b1;
            end
            // Close the varint on any response
            if (rsp_valid_in && !rsp_valid_ff) begin
               dec_seen_in = '0;
               for (int i = 0; i < vuc_pkg::MaxBytes; i++) begin
                  slot_in[i] = '0;
               end
            end else if (!req_payload.byte_in[vuc_pkg::ByteWidth-1] ||
                         (seen_next >= vuc_pkg::SeenBits'(vuc_pkg::MaxBytes)) ||
                         req_payload.end_of_buffer) begin
               dec_seen_in = '0;
               for (int i = 0; i < vuc_pkg::MaxBytes; i++) begin
                  slot_in[i] = '0;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         enc_busy_ff  <= 1'b0;
         enc_count_ff <= '0;
         dec_seen_ff  <= '0;
         for (int i = 0; i < vuc_pkg::MaxBytes; i++) begin
            slot_ff[i] <= '0;
         end
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         enc_busy_ff  <= enc_busy_in;
         enc_count_ff <= enc_count_in;
         dec_seen_ff  <= dec_seen_in;
         slot_ff      <= slot_in;
      end
      rsp_data_ff  <= rsp_data_in;
      enc_value_ff <= enc_value_in;
   end

   // The encoder runs only while one of its bytes sits in the output register
   a_busy_has_rsp: assert property (@(posedge clock) disable iff (reset)
      enc_busy_ff |-> rsp_valid_ff)
      else $error("encoder busy without a pending response");

   // A response that is not the last one only comes from an encode in progress
   a_not_last_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_data_ff.last) |-> enc_busy_ff)
      else $error("non-final response outside an encode");

   // The encoder never runs past the longest encoding
   a_enc_count: assert property (@(posedge clock) disable iff (reset)
      enc_busy_ff |-> (enc_count_ff != '0 &&
                       enc_count_ff < vuc_pkg::SeenBits'(vuc_pkg::HardBytes)))
      else $error("encoder byte count out of range");

   // An open varint never holds the byte limit
   a_dec_seen: assert property (@(posedge clock) disable iff (reset)
      dec_seen_ff < vuc_pkg::SeenBits'(vuc_pkg::MaxBytes))
      else $error("decode byte count reached the limit");

   // A finished decode leaves the byte count cleared
   a_dec_close: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_payload.action == vuc_pkg::ActDecode &&
       !req_payload.byte_in[vuc_pkg::ByteWidth-1]) |=> dec_seen_ff == '0)
      else $error("decode state not cleared after a complete varint");

endmodule

[tb/sv/tb.sv]
// Self-checking testbench for varint_u64_codec, the unsigned 64-bit LEB128 encoder/decoder.
// Uses vuc_pkg for the request/response structs and format constants; needs only the RTL.
`timescale 1ns / 1ps

import vuc_pkg::*;

// Scoreboard: mirrors the codec's decode state and queues the responses that
// each accepted request must produce, in order.
class varint_scoreboard;
   rsp_type               pending_results[$];
   logic [ValueWidth-1:0] partial_value;
   int                    groups_taken;
   int                    failures;
   int                    encodes, decodes, bytes_out, values_out, short_errs, long_errs;

   function new();
      partial_value = '0;
      groups_taken  = 0;
      failures      = 0;
      encodes       = 0;
      decodes       = 0;
      bytes_out     = 0;
      values_out    = 0;
      short_errs    = 0;
      long_errs     = 0;
   endfunction

   function int pending();
      return pending_results.size();
   endfunction

   function void push_result(logic [KindWidth-1:0] kind, logic [ByteWidth-1:0] byte_val,
                             logic [ValueWidth-1:0] value, logic [LengthWidth-1:0] len,
                             logic [StatusWidth-1:0] status, logic is_last);
      rsp_type r;
      r.kind      = kind;
      r.byte_out  = byte_val;
      r.value_out = value;
      r.length    = len;
      r.status    = status;
      r.last      = is_last;
      pending_results.push_back(r);
   endfunction

   // Work out every response that an accepted request causes.
   function void note_request(req_type req);
      logic [ValueWidth-1:0] rest;
      logic [ValueWidth-1:0] group;
      int                    emitted;
      if (req.action == ActEncode) begin
         encodes++;
         rest    = req.value_in & ValueMask;
         emitted = 0;
         while (rest >= 128 && emitted < HardBytes - 1) begin
            push_result(KindByte, {1'b1, rest[6:0]}, '0, '0, StOk, 1'b0);
            rest = rest >> GroupBits;
            emitted++;
         end
         push_result(KindByte, {1'b0, rest[6:0]}, '0, '0, StOk, 1'b1);
         bytes_out += emitted + 1;
      end else begin
         decodes++;
         group = {{(ValueWidth-7){1'b0}}, req.byte_in[6:0]};
         // Drop group bits that land at or past the top of the value.
         if (groups_taken * GroupBits < ValueWidth)
            partial_value |= group << (groups_taken * GroupBits);
         partial_value &= ValueMask;
         if (groups_taken < 15)
            groups_taken++;
         if (!req.byte_in[7]) begin
            push_result(KindValue, '0, partial_value, LengthWidth'(groups_taken), StOk, 1'b1);
            values_out++;
            partial_value = '0;
            groups_taken  = 0;
         end else if (groups_taken >= MaxBytes) begin
            push_result(KindError, '0, '0, '0, StBadData, 1'b1);
            long_errs++;
            partial_value = '0;
            groups_taken  = 0;
         end else if (req.end_of_buffer) begin
            push_result(KindError, '0, '0, '0, StTooShort, 1'b1);
            short_errs++;
            partial_value = '0;
            groups_taken  = 0;
         end
      end
   endfunction

   function void compare_field(string field, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
         failures++;
      end
   endfunction

   function void check_response(rsp_type got);
      rsp_type want;
      if (pending_results.size() == 0) begin
         $display("%0t: unexpected response, expected none, actual %h", $time, got);
         failures++;
      end else begin
         want = pending_results.pop_front();
         compare_field("kind",      64'(want.kind),     64'(got.kind));
         compare_field("byte_out",  64'(want.byte_out), 64'(got.byte_out));
         compare_field("value_out", want.value_out,     got.value_out);
         compare_field("length",    64'(want.length),   64'(got.length));
         compare_field("status",    64'(want.status),   64'(got.status));
         compare_field("last",      64'(want.last),     64'(got.last));
      end
   endfunction
endclass

module tb;

   localparam int TotalRequests = 130;
   localparam int DrainCycles   = 20;
   localparam int WatchdogLimit = 2000;

   typedef enum {SeqWell, SeqShort, SeqLong, SeqNoise} varint_shape_type;

   logic    clock       = 1'b0;
   logic    reset       = 1'b1;
   logic    req_valid   = 1'b0;
   logic    req_ready;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_ready   = 1'b0;
   rsp_type rsp_payload;

   varint_scoreboard sb = new();

   // When calm is set, both sides run without gaps.
   logic calm          = 1'b0;
   int   rsp_hold      = 0;
   int   idle_cycles   = 0;
   int   requests_sent = 0;

   varint_u64_codec uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Mostly short gaps, now and then a long one.
   function automatic int pick_gap();
      if ($urandom_range(0, 9) == 0)
         return $urandom_range(8, 30);
      return $urandom_range(1, 3);
   endfunction

   function automatic logic [63:0] random_value();
      logic [63:0] v;
      int          width;
      v     = {$urandom, $urandom};
      width = $urandom_range(1, 64);
      // Spread the encoded length: trim to a random width, sometimes go all-ones.
      if ($urandom_range(0, 9) == 0)
         return '1;
      if (width < 64)
         v &= (64'd1 << width) - 64'd1;
      return v;
   endfunction

   // Response side: check each accepted response, then pick the next ready.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready)
            sb.check_response(rsp_payload);
         if (rsp_hold > 0) begin
            rsp_hold--;
            rsp_ready <= 1'b0;
         end else if (!calm && $urandom_range(0, 3) == 0) begin
            rsp_hold = pick_gap() - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Watchdog: end the run when neither channel moves for too long.
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= WatchdogLimit) begin
            $display("%0t: no handshake for %0d cycles", $time, WatchdogLimit);
            $display("Verification failed");
            $finish;
         end
      end
   end

   // Drive one request, hold it until accepted, then maybe drop valid for a gap.
   // Leave valid high when no gap follows so the next request goes out back to back.
   task automatic send_request(input req_type req);
      req_valid   <= 1'b1;
      req_payload <= req;
      do
         @(posedge clock);
      while (!req_ready);
      sb.note_request(req);
      requests_sent++;
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat (pick_gap()) @(posedge clock);
      end
   endtask

   // Fill the fields the action ignores with noise.
   task automatic send_encode(input logic [63:0] value);
      req_type req;
      req.action        = ActEncode;
      req.value_in      = value;
      req.byte_in       = 8'($urandom);
      req.end_of_buffer = 1'($urandom_range(0, 1));
      send_request(req);
   endtask

   task automatic send_decode(input logic [7:0] byte_val, input logic eob);
      req_type req;
      req.action        = ActDecode;
      req.value_in      = {$urandom, $urandom};
      req.byte_in       = byte_val;
      req.end_of_buffer = eob;
      send_request(req);
   endtask

   // Feed one varint of the given shape, with the odd encode slipped in mid-stream.
   task automatic send_varint(input varint_shape_type shape);
      int          nbytes;
      logic [7:0]  byte_val;
      logic        eob;
      logic        is_last;
      case (shape)
         SeqWell:  nbytes = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 2)
                                                         : $urandom_range(1, MaxBytes);
         SeqShort: nbytes = $urandom_range(1, MaxBytes - 1);
         SeqLong:  nbytes = MaxBytes;
         default:  nbytes = $urandom_range(1, 4);
      endcase
      for (int i = 0; i < nbytes; i++) begin
         is_last  = (i == nbytes - 1);
         byte_val = 8'($urandom);
         eob      = 1'b0;
         case (shape)
            SeqWell: begin
               byte_val[7] = !is_last;
               if (is_last)
                  eob = 1'($urandom_range(0, 1));
            end
            SeqShort: begin
               byte_val[7] = 1'b1;
               eob         = is_last;
            end
            SeqLong: begin
               // Bad data wins over end of buffer on the limit byte.
               byte_val[7] = 1'b1;
               if (is_last)
                  eob = 1'($urandom_range(0, 1));
            end
            default: eob = ($urandom_range(0, 9) == 0);
         endcase
         if (!is_last && $urandom_range(0, 9) == 0)
            send_encode(random_value());
         send_decode(byte_val, eob);
      end
   endtask

   initial begin
      int pick;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed: encode extremes (one byte, two bytes, ten bytes).
      send_encode(64'd0);
      send_encode(64'd128);
      send_encode('1);

      // Single zero byte decodes to value 0, length 1.
      send_decode(8'h00, 1'b0);
      // Continuing byte at end of buffer: too short.
      send_decode(8'h80, 1'b1);
      // Encode in the middle of a decode must not disturb it: expect 257.
      send_decode(8'h81, 1'b0);
      send_encode(64'd300);
      send_decode(8'h02, 1'b0);

      // Ten-byte varint whose top group overflows 64 bits: excess bits dropped.
      repeat (MaxBytes - 1) send_decode(8'hff, 1'b0);
      send_decode(8'h7f, 1'b1);

      // Tenth byte still continuing: bad data.
      repeat (MaxBytes) send_decode(8'h80, 1'b0);

      // Random part until the total request count is reached: a mix of encodes,
      // well-formed varints, broken varints and noise.
      while (requests_sent < TotalRequests) begin
         if ($urandom_range(0, 9) == 0)
            calm <= !calm;
         pick = $urandom_range(0, 99);
         if (pick < 25)
            send_encode(random_value());
         else if (pick < 70)
            send_varint(SeqWell);
         else if (pick < 80)
            send_varint(SeqShort);
         else if (pick < 88)
            send_varint(SeqLong);
         else
            send_varint(SeqNoise);
      end

      // Stop driving, drain every expected response, then watch for strays.
      req_valid <= 1'b0;
      while (sb.pending() != 0)
         @(posedge clock);
      repeat (DrainCycles) @(posedge clock);

      $display("Covered %0d encode requests (%0d bytes out) and %0d decode bytes.",
               sb.encodes, sb.bytes_out, sb.decodes);
      $display("Decoded %0d values, flagged %0d too-short and %0d bad-data varints.",
               sb.values_out, sb.short_errs, sb.long_errs);
      if (sb.failures == 0 && sb.pending() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

[varint_u64_codec.f]
hdl/vuc_pkg.sv
hdl/varint_u64_codec.sv
tb/sv/tb.sv
